FILE: rtl/core/tdt_pkg.sv
`default_nettype none

package tdt_pkg;

   // Input opcodes.
   localparam logic OP_REGISTER = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   // Result kinds.
   localparam logic KIND_EDGE  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   // Status codes carried by the closing result.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_TABLE_FULL  = 2'd1;
   localparam logic [1:0] ST_READER_FULL = 2'd2;

   // Field widths fixed by the interface.
   localparam int ID_W   = 6;
   localparam int ADDR_W = 64;
   localparam int CNT_W  = 6;

   // The edge counter saturates here.
   localparam logic [CNT_W-1:0] EDGE_MAX = 6'd63;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_DISPATCH,
      S_WALK_RD,
      S_WALK_EDGE,
      S_WR_EDGE,
      S_FIND_RD,
      S_FIND_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_CLOSE
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/tdt_ram.sv
`default_nettype none

// Simple dual-port synchronous memory: one write and one registered read per cycle.
// The read data holds its value while no read is issued.
module tdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/task_dependence_tracker_core.sv
`default_nettype none

// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | opcode, task_id, dep_address, is_writer,
//         |           |                    | last_of_task
// rsp     | out       | rsp_valid/rsp_stall | kind, pred_task_id, edge_count, status, last
//
// One transaction is worked on at a time. Between accepts: the accept, a load of the task's
// row, the address search, a dispatch step, a read step and an edge, check or write step for
// each reader walked, searched or moved (a single step for a lone writer edge) and a closing
// step, plus any result-side stall.
// Reset clears the valid bits of the table and of the task rows at once; no sweep is needed.
// While the result register is stalled the sequencer waits where it must emit a new result.
module task_dependence_tracker_core #(
   parameter int TABLE_ENTRIES = 16,
   parameter int MAX_READERS   = 8,
   parameter int MAX_TASKS     = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_opcode,
   input  wire logic [tdt_pkg::ID_W-1:0]   req_task_id,
   input  wire logic [tdt_pkg::ADDR_W-1:0] req_dep_address,
   input  wire logic                       req_is_writer,
   input  wire logic                       req_last_of_task,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_kind,
   output logic      [tdt_pkg::ID_W-1:0]   rsp_pred_task_id,
   output logic      [tdt_pkg::CNT_W-1:0]  rsp_edge_count,
   output logic      [1:0]                 rsp_status,
   output logic                            rsp_last
);

   import tdt_pkg::*;

   localparam int EW    = $clog2(TABLE_ENTRIES);
   localparam int RW    = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
   localparam int CW    = $clog2(MAX_READERS + 1);
   localparam int TW    = $clog2(MAX_TASKS);
   localparam int WORD  = ADDR_W + TW + 1 + CW;
   localparam int RDEPTH = TABLE_ENTRIES << RW;

   // Control state.
   state_type state_ff, state_in;
   logic [TABLE_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic [MAX_TASKS-1:0]     row_valid_ff, row_valid_in;
   logic [CNT_W-1:0]         edge_cnt_ff, edge_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Item payload and working registers.
   logic              op_ff, op_in;
   logic [TW-1:0]     tid_ff, tid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              wr_ff, wr_in;
   logic              lastf_ff, lastf_in;
   logic [MAX_TASKS-1:0] row_ff, row_in;
   logic [EW:0]       scan_ff, scan_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [EW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              free_found_ff, free_found_in;
   logic [EW-1:0]     free_idx_ff, free_idx_in;
   logic              hit_ff, hit_in;
   logic [EW-1:0]     tgt_ff, tgt_in;
   logic [TW-1:0]     old_wid_ff, old_wid_in;
   logic              old_wv_ff, old_wv_in;
   logic [CW-1:0]     old_cnt_ff, old_cnt_in;
   logic [TW-1:0]     new_wid_ff, new_wid_in;
   logic              new_wv_ff, new_wv_in;
   logic [CW-1:0]     new_cnt_ff, new_cnt_in;
   logic              ent_wr_ff, ent_wr_in;
   logic [1:0]        status_ff, status_in;
   logic [CW-1:0]     slot_ff, slot_in;

   // Result register.
   logic              kind_ff, kind_in;
   logic [ID_W-1:0]   pred_ff, pred_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        rstat_ff, rstat_in;
   logic              rlast_ff, rlast_in;

   // Memory ports.
   logic              ent_rd_en, ent_wr_en;
   logic [EW-1:0]     ent_rd_addr;
   logic [WORD-1:0]   ent_rd_data, ent_wr_data;
   logic              rdr_rd_en, rdr_wr_en;
   logic [EW+RW-1:0]  rdr_rd_addr, rdr_wr_addr;
   logic [TW-1:0]     rdr_rd_data, rdr_wr_data;
   logic              row_rd_en, row_wr_en;
   logic [TW-1:0]     row_rd_addr;
   logic [MAX_TASKS-1:0] row_rd_data;

   // Helpers.
   logic              accept;
   logic              out_free;
   logic [TW-1:0]     req_tid;
   logic [ID_W-1:0]   tid_lut [64];
   logic [ADDR_W-1:0] rd_addr_f;
   logic [TW-1:0]     rd_wid_f;
   logic              rd_wv_f;
   logic [CW-1:0]     rd_cnt_f;
   logic              match;
   logic              cmp_last;
   logic [TW-1:0]     pred_sel;
   logic              edge_new;
   logic [CW:0]       slot_p1, slot_p2, old_cnt_x;

   // Task id folded into the task range through a small constant table.
   for (genvar g = 0; g < 64; g++) begin : g_tid
      assign tid_lut[g] = ID_W'(g % MAX_TASKS);
   end
   assign req_tid = tid_lut[req_task_id][TW-1:0];

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Entry word: address, last writer, writer valid, reader count.
   assign {rd_addr_f, rd_wid_f, rd_wv_f, rd_cnt_f} = ent_rd_data;
   assign match    = cmp_vld_ff && entry_valid_ff[cmp_idx_ff] && (rd_addr_f == addr_ff);
   assign cmp_last = (cmp_idx_ff == EW'(TABLE_ENTRIES - 1));

   // Candidate predecessor and duplicate filter.
   assign pred_sel = (state_ff == S_WR_EDGE) ? old_wid_ff : rdr_rd_data;
   assign edge_new = (pred_sel != tid_ff) && !row_ff[pred_sel];

   assign slot_p1   = {1'b0, slot_ff} + (CW+1)'(1);
   assign slot_p2   = {1'b0, slot_ff} + (CW+1)'(2);
   assign old_cnt_x = {1'b0, old_cnt_ff};

   tdt_ram #(.WIDTH(WORD), .DEPTH(TABLE_ENTRIES), .AW(EW)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   tdt_ram #(.WIDTH(TW), .DEPTH(RDEPTH), .AW(EW+RW)) u_reader_ram (
      .clock   (clock),
      .wr_en   (rdr_wr_en),
      .wr_addr (rdr_wr_addr),
      .wr_data (rdr_wr_data),
      .rd_en   (rdr_rd_en),
      .rd_addr (rdr_rd_addr),
      .rd_data (rdr_rd_data)
   );

   tdt_ram #(.WIDTH(MAX_TASKS), .DEPTH(MAX_TASKS), .AW(TW)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (tid_ff),
      .wr_data (row_ff),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_LOAD;
         end
         S_LOAD: state_in = S_SCAN;
         S_SCAN: begin
            if (match || (cmp_vld_ff && cmp_last)) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (op_ff == OP_REGISTER) begin
               if (!hit_ff) begin
                  state_in = S_CLOSE;
               end else if (wr_ff) begin
                  if (old_cnt_ff != '0)  state_in = S_WALK_RD;
                  else if (old_wv_ff)    state_in = S_WR_EDGE;
                  else                   state_in = S_CLOSE;
               end else begin
                  if (old_cnt_x < (CW+1)'(MAX_READERS) && old_wv_ff) state_in = S_WR_EDGE;
                  else                                              state_in = S_CLOSE;
               end
            end else begin
               if (hit_ff && !wr_ff && old_cnt_ff != '0) state_in = S_FIND_RD;
               else                                      state_in = S_CLOSE;
            end
         end
         S_WALK_RD: state_in = S_WALK_EDGE;
         S_WALK_EDGE: begin
            if (!edge_new || out_free) begin
               state_in = (slot_p1 < old_cnt_x) ? S_WALK_RD : S_CLOSE;
            end
         end
         S_WR_EDGE: begin
            if (!edge_new || out_free) state_in = S_CLOSE;
         end
         S_FIND_RD: state_in = S_FIND_CHK;
         S_FIND_CHK: begin
            if (rdr_rd_data == tid_ff) begin
               state_in = (slot_p1 < old_cnt_x) ? S_SHIFT_RD : S_CLOSE;
            end else begin
               state_in = (slot_p1 < old_cnt_x) ? S_FIND_RD : S_CLOSE;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = (slot_p2 < old_cnt_x) ? S_SHIFT_RD : S_CLOSE;
         S_CLOSE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory strobes and result register loads.
   always_comb begin
      entry_valid_in = entry_valid_ff;
      row_valid_in   = row_valid_ff;
      edge_cnt_in    = edge_cnt_ff;
      op_in = op_ff; tid_in = tid_ff; addr_in = addr_ff; wr_in = wr_ff; lastf_in = lastf_ff;
      row_in = row_ff; scan_in = scan_ff; cmp_vld_in = 1'b0; cmp_idx_in = cmp_idx_ff;
      free_found_in = free_found_ff; free_idx_in = free_idx_ff;
      hit_in = hit_ff; tgt_in = tgt_ff;
      old_wid_in = old_wid_ff; old_wv_in = old_wv_ff; old_cnt_in = old_cnt_ff;
      new_wid_in = new_wid_ff; new_wv_in = new_wv_ff; new_cnt_in = new_cnt_ff;
      ent_wr_in = ent_wr_ff; status_in = status_ff; slot_in = slot_ff;
      kind_in = kind_ff; pred_in = pred_ff; count_in = count_ff;
      rstat_in = rstat_ff; rlast_in = rlast_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      ent_rd_en   = 1'b0;
      ent_rd_addr = scan_ff[EW-1:0];
      ent_wr_en   = 1'b0;
      ent_wr_data = {addr_ff, new_wid_ff, new_wv_ff, new_cnt_ff};
      rdr_rd_en   = 1'b0;
      rdr_rd_addr = {tgt_ff, slot_ff[RW-1:0]};
      rdr_wr_en   = 1'b0;
      rdr_wr_addr = {tgt_ff, slot_ff[RW-1:0]};
      rdr_wr_data = tid_ff;
      row_rd_en   = accept;
      row_rd_addr = req_tid;
      row_wr_en   = 1'b0;

      unique case (state_ff)
         // Capture the transaction and start the row read.
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               tid_in   = req_tid;
               addr_in  = req_dep_address;
               wr_in    = req_is_writer;
               lastf_in = req_last_of_task;
            end
         end
         // Take the task's row and prepare the search.
         S_LOAD: begin
            row_in        = row_valid_ff[tid_ff] ? row_rd_data : '0;
            scan_in       = '0;
            free_found_in = 1'b0;
            hit_in        = 1'b0;
            status_in     = ST_OK;
            ent_wr_in     = 1'b0;
         end
         // Read one entry a cycle and compare the one read before.
         S_SCAN: begin
            if (scan_ff < (EW+1)'(TABLE_ENTRIES)) begin
               ent_rd_en  = 1'b1;
               scan_in    = scan_ff + (EW+1)'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[EW-1:0];
            end
            if (cmp_vld_ff && !entry_valid_ff[cmp_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            if (match) begin
               hit_in     = 1'b1;
               tgt_in     = cmp_idx_ff;
               old_wid_in = rd_wid_f;
               old_wv_in  = rd_wv_f;
               old_cnt_in = rd_cnt_f;
               new_wid_in = rd_wid_f;
               new_wv_in  = rd_wv_f;
               new_cnt_in = rd_cnt_f;
            end
         end
         // Decide the update from the search outcome.
         S_DISPATCH: begin
            slot_in = '0;
            if (op_ff == OP_REGISTER) begin
               if (!hit_ff) begin
                  if (!free_found_ff) begin
                     status_in = ST_TABLE_FULL;
                  end else begin
                     ent_wr_in  = 1'b1;
                     tgt_in     = free_idx_ff;
                     new_wid_in = tid_ff;
                     new_wv_in  = wr_ff;
                     new_cnt_in = wr_ff ? '0 : CW'(1);
                     if (!wr_ff) begin
                        rdr_wr_en   = 1'b1;
                        rdr_wr_addr = {free_idx_ff, RW'(0)};
                     end
                  end
               end else if (wr_ff) begin
                  ent_wr_in  = 1'b1;
                  new_wid_in = tid_ff;
                  new_wv_in  = 1'b1;
                  new_cnt_in = '0;
               end else if (old_cnt_x >= (CW+1)'(MAX_READERS)) begin
                  status_in = ST_READER_FULL;
               end else begin
                  ent_wr_in   = 1'b1;
                  new_cnt_in  = old_cnt_ff + CW'(1);
                  rdr_wr_en   = 1'b1;
                  rdr_wr_addr = {tgt_ff, old_cnt_ff[RW-1:0]};
               end
            end else if (hit_ff) begin
               ent_wr_in = 1'b1;
               if (wr_ff && old_wv_ff && old_wid_ff == tid_ff) begin
                  new_wv_in = 1'b0;
               end
            end
         end
         // Reader walk of a write registration.
         S_WALK_RD: begin
            rdr_rd_en = 1'b1;
         end
         S_WALK_EDGE, S_WR_EDGE: begin
            if (edge_new && out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_EDGE;
               pred_in      = ID_W'(pred_sel);
               count_in     = '0;
               rstat_in     = ST_OK;
               rlast_in     = 1'b0;
               row_in       = row_ff | (MAX_TASKS'(1) << pred_sel);
               if (edge_cnt_ff != EDGE_MAX) edge_cnt_in = edge_cnt_ff + CNT_W'(1);
            end
            if (!edge_new || out_free) slot_in = slot_p1[CW-1:0];
         end
         // Search for the released reader.
         S_FIND_RD: begin
            rdr_rd_en = 1'b1;
         end
         S_FIND_CHK: begin
            if (rdr_rd_data == tid_ff) begin
               new_cnt_in = old_cnt_ff - CW'(1);
            end else begin
               slot_in = slot_p1[CW-1:0];
            end
         end
         // Close the gap: move each later reader one place down.
         S_SHIFT_RD: begin
            rdr_rd_en   = 1'b1;
            rdr_rd_addr = {tgt_ff, slot_p1[RW-1:0]};
         end
         S_SHIFT_WR: begin
            rdr_wr_en   = 1'b1;
            rdr_wr_data = rdr_rd_data;
            slot_in     = slot_p1[CW-1:0];
         end
         // Closing result and commit of the entry and row.
         S_CLOSE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_CLOSE;
               pred_in      = '0;
               count_in     = (op_ff == OP_REGISTER) ? edge_cnt_ff : '0;
               rstat_in     = status_ff;
               rlast_in     = 1'b1;
               if (ent_wr_ff) begin
                  ent_wr_en = 1'b1;
                  entry_valid_in[tgt_ff] = (op_ff == OP_REGISTER) ||
                                           new_wv_ff || (new_cnt_ff != '0);
               end
               if (op_ff == OP_REGISTER) begin
                  if (lastf_ff) begin
                     row_valid_in[tid_ff] = 1'b0;
                     edge_cnt_in          = '0;
                  end else begin
                     row_wr_en            = 1'b1;
                     row_valid_in[tid_ff] = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_valid_ff <= '0;
         row_valid_ff   <= '0;
         edge_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         cmp_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_valid_ff <= entry_valid_in;
         row_valid_ff   <= row_valid_in;
         edge_cnt_ff    <= edge_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         cmp_vld_ff     <= cmp_vld_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in; tid_ff <= tid_in; addr_ff <= addr_in; wr_ff <= wr_in;
      lastf_ff <= lastf_in; row_ff <= row_in; scan_ff <= scan_in; cmp_idx_ff <= cmp_idx_in;
      free_found_ff <= free_found_in; free_idx_ff <= free_idx_in;
      hit_ff <= hit_in; tgt_ff <= tgt_in;
      old_wid_ff <= old_wid_in; old_wv_ff <= old_wv_in; old_cnt_ff <= old_cnt_in;
      new_wid_ff <= new_wid_in; new_wv_ff <= new_wv_in; new_cnt_ff <= new_cnt_in;
      ent_wr_ff <= ent_wr_in; status_ff <= status_in; slot_ff <= slot_in;
      kind_ff <= kind_in; pred_ff <= pred_in; count_ff <= count_in;
      rstat_ff <= rstat_in; rlast_ff <= rlast_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_pred_task_id = pred_ff;
   assign rsp_edge_count   = count_ff;
   assign rsp_status       = rstat_ff;
   assign rsp_last         = rlast_ff;

endmodule

`default_nettype wire

FILE: tb/tb_task_dependence_tracker_core.sv
`timescale 1ns / 1ps

module tb_task_dependence_tracker_core;
   import tdt_pkg::*;

   localparam int N_ENTRIES = 16;
   localparam int N_READERS = 8;
   localparam int N_TASKS   = 64;
   localparam longint CYCLE_LIMIT = 400000;
   localparam int EXP_DEPTH = 1024;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic             kind;
      logic [ID_W-1:0]  pred;
      logic [CNT_W-1:0] count;
      logic [1:0]       status;
      logic             last;
   } dep_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = OP_REGISTER;
   logic [ID_W-1:0] req_task_id = '0;
   logic [ADDR_W-1:0] req_dep_address = '0;
   logic req_is_writer = 1'b0;
   logic req_last_of_task = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   logic [ID_W-1:0] rsp_pred_task_id;
   logic [CNT_W-1:0] rsp_edge_count;
   logic [1:0] rsp_status;
   logic rsp_last;

   // Predictor state: the address table, reader lists and per-task rows.
   logic             tbl_valid [N_ENTRIES];
   logic [ADDR_W-1:0] tbl_addr [N_ENTRIES];
   logic             wr_valid [N_ENTRIES];
   logic [ID_W-1:0]  wr_id [N_ENTRIES];
   logic [ID_W-1:0]  rd_ids [N_ENTRIES][N_READERS];
   int               rd_count [N_ENTRIES];
   logic [63:0]      dep_row [N_TASKS];
   logic [CNT_W-1:0] edge_cnt;

   // Expected results, in order: the predictor fills, the checker empties.
   dep_result_type exp_fifo [EXP_DEPTH];
   int  exp_head = 0;
   int  exp_tail = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_asked = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  errors = 0;
   longint cycles = 0;
   logic [ADDR_W-1:0] addr_pool [8];

   task_dependence_tracker_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_task_id(req_task_id),
      .req_dep_address(req_dep_address), .req_is_writer(req_is_writer),
      .req_last_of_task(req_last_of_task),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind), .rsp_pred_task_id(rsp_pred_task_id),
      .rsp_edge_count(rsp_edge_count), .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   always #4 clock = ~clock;

   // Cycle counter with the timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_task_dependence_tracker_core: done, errors");
         $finish;
      end
   end

   function automatic void queue_result(input dep_result_type r);
      exp_fifo[exp_tail % EXP_DEPTH] = r;
      exp_tail++;
   endfunction

   function automatic void push_edge(input logic [ID_W-1:0] tid, input logic [ID_W-1:0] pred);
      dep_result_type r;
      if (pred == tid || dep_row[tid][pred]) return;
      dep_row[tid][pred] = 1'b1;
      if (edge_cnt != EDGE_MAX) edge_cnt++;
      r = '{KIND_EDGE, pred, '0, ST_OK, 1'b0};
      queue_result(r);
   endfunction

   // Work out the results of one accepted transaction and update the table.
   function automatic void predict_dependence(input logic op, input logic [ID_W-1:0] tid,
         input logic [ADDR_W-1:0] addr, input logic wr, input logic lastf);
      int hit = -1;
      int fr = -1;
      int c;
      logic [1:0] st = ST_OK;
      dep_result_type r;
      for (int i = 0; i < N_ENTRIES; i++)
         if (hit < 0 && tbl_valid[i] && tbl_addr[i] == addr) hit = i;
      if (op == OP_REGISTER) begin
         if (hit < 0) begin
            for (int i = 0; i < N_ENTRIES; i++)
               if (fr < 0 && !tbl_valid[i]) fr = i;
            if (fr < 0) begin
               st = ST_TABLE_FULL;
            end else begin
               tbl_valid[fr] = 1'b1;
               tbl_addr[fr] = addr;
               wr_valid[fr] = wr;
               wr_id[fr] = tid;
               rd_ids[fr][0] = tid;
               rd_count[fr] = wr ? 0 : 1;
            end
         end else if (wr) begin
            c = rd_count[hit];
            for (int i = 0; i < c; i++) push_edge(tid, rd_ids[hit][i]);
            if (c == 0 && wr_valid[hit]) push_edge(tid, wr_id[hit]);
            wr_valid[hit] = 1'b1;
            wr_id[hit] = tid;
            rd_count[hit] = 0;
         end else begin
            c = rd_count[hit];
            if (c >= N_READERS) begin
               st = ST_READER_FULL;
            end else begin
               if (wr_valid[hit]) push_edge(tid, wr_id[hit]);
               rd_ids[hit][c] = tid;
               rd_count[hit] = c + 1;
            end
         end
         r = '{KIND_CLOSE, '0, edge_cnt, st, 1'b1};
         queue_result(r);
         if (lastf) begin
            edge_cnt = '0;
            dep_row[tid] = '0;
         end
      end else begin
         if (hit >= 0) begin
            if (wr) begin
               if (wr_valid[hit] && wr_id[hit] == tid) wr_valid[hit] = 1'b0;
            end else begin
               c = rd_count[hit];
               for (int i = 0; i < c; i++) begin
                  if (rd_ids[hit][i] == tid) begin
                     for (int k = i; k + 1 < c; k++) rd_ids[hit][k] = rd_ids[hit][k + 1];
                     rd_count[hit] = c - 1;
                     break;
                  end
               end
            end
            if (!wr_valid[hit] && rd_count[hit] == 0) tbl_valid[hit] = 1'b0;
         end
         r = '{KIND_CLOSE, '0, '0, ST_OK, 1'b1};
         queue_result(r);
      end
   endfunction

   // Offer one transaction, with a random gap first, and wait for acceptance.
   task automatic send_dependence(input logic op, input logic [ID_W-1:0] tid,
         input logic [ADDR_W-1:0] addr, input logic wr, input logic lastf);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_task_id <= tid;
      req_dep_address <= addr;
      req_is_writer <= wr;
      req_last_of_task <= lastf;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_dependence(op, tid, addr, wr, lastf);
   endtask

   // Receiver stall: a long hold-off when asked, otherwise random.
   always @(posedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      dep_result_type want;
      dep_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_kind, rsp_pred_task_id, rsp_edge_count, rsp_status, rsp_last};
         if (exp_head == exp_tail) begin
            $display("%0t: unexpected result, expected none actual %p", $time, got);
            errors++;
         end else begin
            want = exp_fifo[exp_head % EXP_DEPTH];
            exp_head++;
            if (got !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   task automatic drain_results;
      req_valid <= 1'b0;
      while (exp_head != exp_tail) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Directed: extremes of the fields, both operations and the special cases.
   task automatic test_directed;
      logic [ADDR_W-1:0] a = 64'hFFFF_FFFF_FFFF_FFFF;
      send_dependence(OP_REGISTER, 6'd0, 64'd0, 1'b1, 1'b1);
      send_dependence(OP_REGISTER, 6'd63, 64'd0, 1'b1, 1'b0);   // edge to the last writer
      send_dependence(OP_REGISTER, 6'd63, 64'd0, 1'b0, 1'b0);   // self edge skipped
      send_dependence(OP_REGISTER, 6'd63, a, 1'b0, 1'b1);
      for (int i = 1; i <= N_READERS; i++)
         send_dependence(OP_REGISTER, 6'(i), a, 1'b0, 1'b1);  // fills the reader list
      send_dependence(OP_REGISTER, 6'd20, a, 1'b1, 1'b1);       // writer after many readers
      for (int i = 1; i <= N_READERS + 1; i++)
         send_dependence(OP_REGISTER, 6'(30 + i), a + i, 1'b0, 1'b1);
      send_dependence(OP_REGISTER, 6'd21, 64'h5555, 1'b1, 1'b1);
      send_dependence(OP_RELEASE, 6'd20, a, 1'b1, 1'b1);        // frees an entry
      send_dependence(OP_RELEASE, 6'd5, 64'h1234, 1'b0, 1'b0);  // unknown address
      send_dependence(OP_RELEASE, 6'd63, 64'd0, 1'b1, 1'b0);
      drain_results();
   endtask

   // Release everything still held so the table is empty again.
   task automatic test_cleanup;
      for (int e = 0; e < N_ENTRIES; e++) begin
         if (tbl_valid[e]) begin
            if (wr_valid[e]) send_dependence(OP_RELEASE, wr_id[e], tbl_addr[e], 1'b1, 1'b0);
            while (tbl_valid[e] && rd_count[e] > 0)
               send_dependence(OP_RELEASE, rd_ids[e][0], tbl_addr[e], 1'b0, 1'b0);
         end
      end
      drain_results();
   endtask

   // Random tasks: a few dependences each, mostly on a small pool of addresses.
   task automatic test_random(input int n_items);
      int sent = 0;
      logic [ID_W-1:0] tid;
      int deps;
      while (sent < n_items) begin
         tid = 6'($urandom);
         deps = $urandom_range(1, 4);
         for (int d = 0; d < deps; d++) begin
            send_dependence(OP_REGISTER, tid,
                  ($urandom_range(9) == 0) ? {$urandom, $urandom} : addr_pool[$urandom_range(7)],
                  1'($urandom_range(1)), d == deps - 1);
            sent++;
         end
         if ($urandom_range(2) != 0) begin
            send_dependence(OP_RELEASE, 6'($urandom),
                  addr_pool[$urandom_range(7)], 1'($urandom_range(1)),
                  1'($urandom_range(1)));
            sent++;
         end
      end
      test_cleanup();
   endtask

   // The receiver holds off while transactions keep arriving.
   task automatic test_backpressure;
      hold_asked = hold_asked + 1;
      test_random(20);
   endtask

   initial begin
      foreach (tbl_valid[i]) begin
         tbl_valid[i] = 1'b0;
         wr_valid[i] = 1'b0;
         rd_count[i] = 0;
      end
      foreach (dep_row[i]) dep_row[i] = '0;
      edge_cnt = '0;
      foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_cleanup();
      send_idle_pct = 9;
      recv_idle_pct = 61;
      test_random(110);
      send_idle_pct = 61;
      recv_idle_pct = 9;
      test_random(110);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(90);
      test_backpressure();
      drain_results();
      if (errors == 0)
         $display("tb_task_dependence_tracker_core: done, clean");
      else
         $display("tb_task_dependence_tracker_core: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/tdt_pkg.sv
rtl/core/tdt_ram.sv
rtl/core/task_dependence_tracker_core.sv
tb/tb_task_dependence_tracker_core.sv
